>>> src/madf_pkg.sv
package madf_pkg;

    // Window length and sample width
    localparam int WINDOW      = 7;
    localparam int SAMPLE_BITS = 12;
    localparam int THRESH_BITS = 12;
    localparam int AVG_BITS    = 12;

    // Derived widths
    localparam int POS_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = ((AVG_BITS + 7) / 8) * 8;

    // Division by the window length as a multiply by a rounded-up reciprocal.
    // With this shift the quotient is exact for every sum that can occur.
    localparam int DIV_SHIFT = SUM_BITS + $clog2(WINDOW);
    localparam int DIV_RECIP = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int PROD_BITS = SUM_BITS + DIV_SHIFT + 1;

    // Largest value the running sum can take
    localparam int SUM_MAX = WINDOW * ((1 << SAMPLE_BITS) - 1);

    // Threshold after reset
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(100);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [SUM_BITS-1:0]    sum_t;
    typedef logic [POS_BITS-1:0]    pos_t;
    typedef logic [AVG_BITS-1:0]    avg_t;
    typedef logic [THRESH_BITS-1:0] thresh_t;

endpackage

>>> src/moving_average_deadband_filter.sv
// An item accepted into the input register yields its result, if any, on m_tvalid
// through the result register (input register, then result register) when the result register is free.
// Throughput: one item per cycle; while a result is stalled, one more item waits in the
// input register and further input is held off.
// Reset (aresetn, synchronous, active low) clears the sample ring, running sum,
// write position and last sent average to zero, arms the first-result pass and
// sets the change threshold to 100.
module moving_average_deadband_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration: change threshold
    input  logic                              cfg_wr_en,
    input  logic [madf_pkg::THRESH_BITS-1:0]  cfg_wr_data,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [madf_pkg::TDATA_BITS-1:0]   s_tdata,   // [11:0] sample
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [madf_pkg::OUT_BITS-1:0]     m_tdata    // [11:0] average
);

    // Registers
    logic                                     in_valid_reg;
    madf_pkg::sample_t                        in_sample_reg;
    madf_pkg::sample_t                        ring_reg [madf_pkg::WINDOW];
    madf_pkg::pos_t                           pos_reg;
    madf_pkg::sum_t                           running_sum_reg;
    madf_pkg::avg_t                           last_sent_reg;
    logic                                     none_sent_yet_reg;
    madf_pkg::thresh_t                        thresh_reg;
    logic                                     m_tvalid_reg;
    madf_pkg::avg_t                           m_avg_reg;

    // Combinational values
    logic                                     proc_fire;
    madf_pkg::sample_t                        old_sample;
    madf_pkg::sum_t                           sum_next;
    logic [madf_pkg::PROD_BITS-1:0]           prod;
    madf_pkg::avg_t                           avg;
    madf_pkg::avg_t                           diff;
    logic                                     send;
    madf_pkg::pos_t                           pos_next;

    // The held item is processed whenever the result register is free or draining.
    always_comb begin
        proc_fire = in_valid_reg && (!m_tvalid_reg || m_tready);
        s_tready  = !in_valid_reg || proc_fire;
    end

    // Ring update, window average and deadband decision.
    always_comb begin
        old_sample = ring_reg[pos_reg];
        sum_next   = running_sum_reg - madf_pkg::SUM_BITS'(old_sample)
                     + madf_pkg::SUM_BITS'(in_sample_reg);
        prod       = madf_pkg::PROD_BITS'(sum_next)
                     * madf_pkg::PROD_BITS'(madf_pkg::DIV_RECIP);
        avg        = madf_pkg::AVG_BITS'(prod >> madf_pkg::DIV_SHIFT);
        diff       = (avg >= last_sent_reg) ? (avg - last_sent_reg) : (last_sent_reg - avg);
        send       = none_sent_yet_reg || (diff > thresh_reg);
        pos_next   = (pos_reg == madf_pkg::POS_BITS'(madf_pkg::WINDOW - 1))
                     ? '0 : pos_reg + madf_pkg::POS_BITS'(1);
    end

    // Control state, ring and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            pos_reg           <= '0;
            running_sum_reg   <= '0;
            last_sent_reg     <= '0;
            none_sent_yet_reg <= 1'b1;
            thresh_reg        <= madf_pkg::THRESH_RESET;
            m_tvalid_reg      <= 1'b0;
            for (int i = 0; i < madf_pkg::WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end

            if (proc_fire) begin
                ring_reg[pos_reg] <= in_sample_reg;
                pos_reg           <= pos_next;
                running_sum_reg   <= sum_next;
                m_tvalid_reg      <= send;
                if (send) begin
                    last_sent_reg     <= avg;
                    none_sent_yet_reg <= 1'b0;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[madf_pkg::SAMPLE_BITS-1:0];
        end
        if (proc_fire && send) begin
            m_avg_reg <= avg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = madf_pkg::OUT_BITS'(m_avg_reg);

    // The running sum stays within the window's largest possible total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        running_sum_reg <= madf_pkg::SUM_BITS'(madf_pkg::SUM_MAX))
        else $error("running sum beyond window maximum");

    // The write position always addresses a slot of the ring.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= madf_pkg::POS_BITS'(madf_pkg::WINDOW - 1))
        else $error("write position outside ring");

    // A result on the output means the first-result pass has been used.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !none_sent_yet_reg)
        else $error("result shown while first pass still armed");

    // A held item facing a stalled result blocks new input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline is full");

    // A sent average becomes the new reference.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && send) |=> (last_sent_reg == m_avg_reg) && m_tvalid_reg)
        else $error("reference not updated with sent average");

endmodule
